// ===== hdl/lp2sc_pkg.sv =====
`default_nettype none

package lp2sc_pkg;

  // Queue between parser and result expander, in commands
  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] START_CODE = 32'h0000_0001;
  localparam logic [7:0]  LEN_SIZE_MASK = 8'h03;

  // Parser phases within one tag body
  typedef enum logic [3:0] {
    PH_HEAD      = 4'd0,
    PH_CFG       = 4'd1,
    PH_SPS_LEN   = 4'd2,
    PH_SPS_DATA  = 4'd3,
    PH_PPS_COUNT = 4'd4,
    PH_PPS_LEN   = 4'd5,
    PH_PPS_DATA  = 4'd6,
    PH_TRAIL     = 4'd7,
    PH_NAL_LEN   = 4'd8,
    PH_NAL_DATA  = 4'd9,
    PH_EOS       = 4'd10
  } phase_e;

  // What one accepted item asks the back end to emit
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,  // four start code bytes
    CMD_DATA   = 2'd1,  // one payload byte
    CMD_STATUS = 2'd2   // one status-only result
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        tag_end;
    logic        seq_end;
    logic        trunc;
    logic [31:0] pts;
  } cmd_t;

  // Byte idx (0 first) of the big-endian start code
  function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
    logic [1:0] rev;
    rev = ~idx;
    return START_CODE[{rev, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lp2sc_front.sv =====
`default_nettype none

module lp2sc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             in_last_i,
  input  wire logic [31:0]      dts_in_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output lp2sc_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] POS_MAX    = 4'd15;
  localparam logic [3:0] POS_KIND   = 4'd1;
  localparam logic [3:0] POS_HDR_END = 4'd4;
  localparam logic [3:0] POS_LEN_SZ = 4'd9;
  localparam logic [3:0] POS_CFG_END = 4'd10;
  localparam logic [1:0] SPS_PPS_LEN_M1 = 2'd1;
  localparam logic [1:0] NAL_LEN_M1_RST = 2'd3;

  lp2sc_pkg::phase_e phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [1:0]  seen_q, seen_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  logic [1:0]  lsz_q, lsz_d;     // NAL length size minus one
  logic [7:0]  kind_q, kind_d;
  logic [23:0] comp_q, comp_d;
  logic [31:0] dts_q, dts_d;

  logic        in_fire;
  logic        emit_start, emit_data;
  logic        take_len, in_data, len_done;
  logic [1:0]  len_m1;
  logic [31:0] acc_shift, rem_dec;
  logic        trunc, seq;

  assign in_ready_o = !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = (pos_q == POS_MAX) ? pos_q : pos_q + 4'd1;
    seen_d     = seen_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    lsz_d      = lsz_q;
    kind_d     = kind_q;
    comp_d     = comp_q;
    dts_d      = dts_q;
    emit_start = 1'b0;
    emit_data  = 1'b0;
    trunc      = 1'b1;
    seq        = 1'b0;

    take_len  = (phase_q == lp2sc_pkg::PH_SPS_LEN) || (phase_q == lp2sc_pkg::PH_PPS_LEN) ||
                (phase_q == lp2sc_pkg::PH_NAL_LEN);
    in_data   = (phase_q == lp2sc_pkg::PH_SPS_DATA) || (phase_q == lp2sc_pkg::PH_PPS_DATA) ||
                (phase_q == lp2sc_pkg::PH_NAL_DATA);
    len_m1    = (phase_q == lp2sc_pkg::PH_NAL_LEN) ? lsz_q : SPS_PPS_LEN_M1;
    len_done  = (seen_q == len_m1);
    acc_shift = {acc_q[23:0], in_byte_i};
    rem_dec   = rem_q - 32'd1;

    case (phase_q)
      lp2sc_pkg::PH_HEAD: begin
        if (pos_q == '0) begin
          dts_d  = dts_in_i;
          comp_d = '0;
          kind_d = '0;
        end else if (pos_q == POS_KIND) begin
          kind_d = in_byte_i;
        end else begin
          comp_d = {comp_q[15:0], in_byte_i};
        end
        if (pos_q >= POS_HDR_END) begin
          seen_d = '0;
          acc_d  = '0;
          if (kind_q == 8'd0) begin
            phase_d = lp2sc_pkg::PH_CFG;
          end else if (kind_q == 8'd1) begin
            phase_d = lp2sc_pkg::PH_NAL_LEN;
          end else begin
            phase_d = lp2sc_pkg::PH_EOS;
          end
        end
      end
      lp2sc_pkg::PH_CFG: begin
        if (pos_q == POS_LEN_SZ) begin
          lsz_d = 2'(in_byte_i & lp2sc_pkg::LEN_SIZE_MASK);
        end
        if (pos_q >= POS_CFG_END) begin
          phase_d = lp2sc_pkg::PH_SPS_LEN;
        end
      end
      lp2sc_pkg::PH_SPS_LEN: begin
        if (len_done) begin
          phase_d = (acc_shift != '0) ? lp2sc_pkg::PH_SPS_DATA : lp2sc_pkg::PH_PPS_COUNT;
        end
      end
      lp2sc_pkg::PH_SPS_DATA: begin
        if (rem_dec == '0) begin
          phase_d = lp2sc_pkg::PH_PPS_COUNT;
        end
      end
      lp2sc_pkg::PH_PPS_COUNT: begin
        phase_d = lp2sc_pkg::PH_PPS_LEN;
      end
      lp2sc_pkg::PH_PPS_LEN: begin
        if (len_done) begin
          phase_d = (acc_shift != '0) ? lp2sc_pkg::PH_PPS_DATA : lp2sc_pkg::PH_TRAIL;
        end
      end
      lp2sc_pkg::PH_PPS_DATA: begin
        if (rem_dec == '0) begin
          phase_d = lp2sc_pkg::PH_TRAIL;
        end
      end
      lp2sc_pkg::PH_NAL_LEN: begin
        if (len_done) begin
          phase_d = (acc_shift != '0) ? lp2sc_pkg::PH_NAL_DATA : lp2sc_pkg::PH_NAL_LEN;
        end
      end
      lp2sc_pkg::PH_NAL_DATA: begin
        if (rem_dec == '0) begin
          phase_d = lp2sc_pkg::PH_NAL_LEN;
        end
      end
      default: begin
      end
    endcase

    // shared length collector
    if (take_len) begin
      if (len_done) begin
        rem_d      = acc_shift;
        acc_d      = '0;
        seen_d     = '0;
        emit_start = 1'b1;
      end else begin
        acc_d  = acc_shift;
        seen_d = seen_q + 2'd1;
      end
    end

    if (in_data) begin
      emit_data = 1'b1;
      rem_d     = rem_dec;
    end

    // end-of-tag status judged on the phase the byte leaves behind
    case (phase_d)
      lp2sc_pkg::PH_TRAIL: begin
        trunc = 1'b0;
      end
      lp2sc_pkg::PH_EOS: begin
        trunc = 1'b0;
        seq   = 1'b1;
      end
      lp2sc_pkg::PH_NAL_LEN: begin
        trunc = (seen_d != '0);
      end
      default: begin
        trunc = 1'b1;
      end
    endcase

    cmd_o.data    = in_byte_i;
    cmd_o.tag_end = in_last_i;
    cmd_o.seq_end = in_last_i && seq;
    cmd_o.trunc   = in_last_i && trunc;
    cmd_o.pts     = dts_d + {8'd0, comp_d};
    if (emit_start) begin
      cmd_o.kind = lp2sc_pkg::CMD_START;
    end else if (emit_data) begin
      cmd_o.kind = lp2sc_pkg::CMD_DATA;
    end else begin
      cmd_o.kind = lp2sc_pkg::CMD_STATUS;
    end
    push_o = in_fire && (emit_start || emit_data || in_last_i);

    if (in_last_i) begin
      pos_d   = '0;
      phase_d = lp2sc_pkg::PH_HEAD;
      seen_d  = '0;
      acc_d   = '0;
      rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lp2sc_pkg::PH_HEAD;
      pos_q   <= '0;
      seen_q  <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      lsz_q   <= NAL_LEN_M1_RST;
      kind_q  <= '0;
      comp_q  <= '0;
      dts_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      seen_q  <= seen_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      lsz_q   <= lsz_d;
      kind_q  <= kind_d;
      comp_q  <= comp_d;
      dts_q   <= dts_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lp2sc_fifo.sv =====
`default_nettype none

module lp2sc_fifo #(
  parameter int unsigned DEPTH = lp2sc_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lp2sc_pkg::cmd_t  push_cmd_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output lp2sc_pkg::cmd_t       head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lp2sc_pkg::cmd_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("command popped from empty queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) || (count_q == CNT_FULL) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// ===== hdl/lp2sc_back.sv =====
`default_nettype none

module lp2sc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             head_valid_i,
  input  wire lp2sc_pkg::cmd_t  head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  byte_valid_o,
  output logic                  run_last_o,
  output logic                  tag_end_o,
  output logic                  sequence_end_o,
  output logic                  truncated_o,
  output logic [31:0]           pts_o
);

  localparam logic [1:0] START_LAST_IDX = 2'd3;

  logic [1:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        bvalid_q, bvalid_d;
  logic        run_last_q, run_last_d;
  logic        tag_end_q, tag_end_d;
  logic        seq_q, seq_d;
  logic        trunc_q, trunc_d;
  logic [31:0] pts_q;
  logic        load, final_res;

  assign load      = head_valid_i && (!out_valid_q || out_ready_i);
  assign final_res = (head_i.kind != lp2sc_pkg::CMD_START) || (cnt_q == START_LAST_IDX);
  assign pop_o     = load && final_res;

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      cnt_d       = final_res ? '0 : cnt_q + 2'd1;
    end

    case (head_i.kind)
      lp2sc_pkg::CMD_START: begin
        byte_d   = lp2sc_pkg::start_code_byte(cnt_q);
        bvalid_d = 1'b1;
      end
      lp2sc_pkg::CMD_DATA: begin
        byte_d   = head_i.data;
        bvalid_d = 1'b1;
      end
      default: begin
        byte_d   = '0;
        bvalid_d = 1'b0;
      end
    endcase
    run_last_d = final_res;
    tag_end_d  = final_res && head_i.tag_end;
    seq_d      = final_res && head_i.seq_end;
    trunc_d    = final_res && head_i.trunc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= byte_d;
      bvalid_q   <= bvalid_d;
      run_last_q <= run_last_d;
      tag_end_q  <= tag_end_d;
      seq_q      <= seq_d;
      trunc_q    <= trunc_d;
      pts_q      <= head_i.pts;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign byte_valid_o   = bvalid_q;
  assign run_last_o     = run_last_q;
  assign tag_end_o      = tag_end_q;
  assign sequence_end_o = seq_q;
  assign truncated_o    = trunc_q;
  assign pts_o          = pts_q;

  a_start_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (head_valid_i && (head_i.kind == lp2sc_pkg::CMD_START)))
    else $error("start code split from its command");

  a_status_ends_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !bvalid_q) |-> (tag_end_q && run_last_q))
    else $error("status result without tag end");

  a_seq_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && seq_q) |-> (!bvalid_q && !trunc_q))
    else $error("end of sequence on a data result or truncated");

endmodule

`default_nettype wire

// ===== hdl/avc_length_prefix_to_start_code_top.sv =====
// An accepted byte's commands go through the queue, then the output register.
// Throughput: one byte per cycle while out_ready_i is high and each byte gives
//   at most one result; a byte that completes a length field gives four start
//   code results, one per cycle, set by the output register; queue hides bursts.
// Reset: rst_ni asynchronous, active low; parser returns to the tag header with
//   a 4-byte NAL length size, queue empties, output goes invalid. No clearing pass.
`default_nettype none

module avc_length_prefix_to_start_code_top #(
  // commands buffered between parser and expander
  parameter int unsigned QUEUE_DEPTH = lp2sc_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tag body bytes
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_last_i,
  input  wire logic [31:0] dts_in_i,
  // start-code delimited stream and status
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             run_last_o,
  output logic             tag_end_o,
  output logic             sequence_end_o,
  output logic             truncated_o,
  output logic [31:0]      pts_o
);

  // Front: tracks the tag layout (header, config record, length fields,
  // payloads) and turns each item into at most one command. A command says
  // "four start code bytes", "one payload byte" or "status only", and carries
  // the end-of-tag flags and pts, so the back end needs no parse state.
  logic            push, q_full, pop, head_valid;
  lp2sc_pkg::cmd_t push_cmd, head_cmd;

  lp2sc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .dts_in_i   (dts_in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Queue: lets the parser run ahead while a start code drains
  lp2sc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_cmd)
  );

  // Back: expands the head command into results, one per cycle while the output
  // is not stalled, into the output register; flags land on its final result only.
  lp2sc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .run_last_o     (run_last_o),
    .tag_end_o      (tag_end_o),
    .sequence_end_o (sequence_end_o),
    .truncated_o    (truncated_o),
    .pts_o          (pts_o)
  );

endmodule

`default_nettype wire

// ===== test/lp2sc_stream_checker.sv =====
module lp2sc_stream_checker #(
  parameter logic [7:0] CONFIG_TYPE = 8'd0,
  parameter logic [7:0] NAL_TYPE    = 8'd1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_last_i,
  input  wire logic [31:0] dts_in_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [7:0]  out_byte_i,
  input  wire logic        byte_valid_i,
  input  wire logic        run_last_i,
  input  wire logic        tag_end_i,
  input  wire logic        sequence_end_i,
  input  wire logic        truncated_i,
  input  wire logic [31:0] pts_i,
  output int               mismatches_o,
  output int               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned  MaxPerByte   = 4;
  localparam int unsigned  MaxPrinted   = 40;
  // offsets within the tag body
  localparam logic [23:0]  HeaderEndPos = 24'd4;
  localparam logic [23:0]  LenSizePos   = 24'd9;
  localparam logic [23:0]  SpsCountPos  = 24'd10;

  typedef struct {
    logic [7:0]  data;
    logic        byte_valid;
    logic        run_last;
    logic        tag_end;
    logic        seq_end;
    logic        trunc;
    logic [31:0] pts;
  } stream_result_t;

  // parser state
  lp2sc_pkg::phase_e phase_q;
  logic [23:0] pos_q;
  logic [2:0]  len_seen_q;
  logic [31:0] len_acc_q;
  logic [31:0] remaining_q;
  logic [2:0]  len_size_q;
  logic [7:0]  kind_q;
  logic [23:0] cts_q;
  logic [31:0] tag_dts_q;

  stream_result_t annexb_queue[$];
  stream_result_t byte_results[$];
  int unsigned    results_seen;

  task automatic report_mismatch(input string msg);
    if (mismatches_o < MaxPrinted)
      $display("%0t ns: result %0d: %s", $time, results_seen, msg);
    mismatches_o++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, should be %0h", field, got, want));
  endtask

  task automatic emit(input logic [7:0] data, input logic has_data);
    stream_result_t r;
    if (byte_results.size() < MaxPerByte) begin
      r = '{default: '0};
      r.data = has_data ? data : 8'h00;
      r.byte_valid = has_data;
      byte_results.insert(byte_results.size(), r);
    end
  endtask

  task automatic emit_start_code();
    for (int k = 0; k < 4; k++)
      emit(lp2sc_pkg::START_CODE[31 - 8 * k -: 8], 1'b1);
  endtask

  task automatic clear_tag();
    pos_q = '0;
    phase_q = lp2sc_pkg::PH_HEAD;
    len_seen_q = '0;
    len_acc_q = '0;
    remaining_q = '0;
  endtask

  // big-endian length field; a complete one opens a NAL with its start code
  task automatic collect_length(input logic [7:0] b, input logic [2:0] width,
                                output bit done);
    len_acc_q = {len_acc_q[23:0], b};
    len_seen_q = len_seen_q + 3'd1;
    done = (len_seen_q >= width);
    if (done) begin
      remaining_q = len_acc_q;
      len_acc_q = '0;
      len_seen_q = '0;
      emit_start_code();
    end
  endtask

  task automatic parse_tag_byte(input logic [7:0] b, input logic last,
                                input logic [31:0] dts);
    bit          done;
    bit          trunc;
    bit          seq;
    logic [31:0] pts;
    trunc = 1'b0;
    seq = 1'b0;
    byte_results.delete();
    case (phase_q)
      lp2sc_pkg::PH_HEAD: begin
        if (pos_q == '0) begin
          tag_dts_q = dts;
          cts_q = '0;
          kind_q = '0;
        end else if (pos_q == 24'd1) begin
          kind_q = b;
        end else begin
          cts_q = {cts_q[15:0], b};
        end
        if (pos_q >= HeaderEndPos) begin
          len_seen_q = '0;
          len_acc_q = '0;
          if (kind_q == CONFIG_TYPE) phase_q = lp2sc_pkg::PH_CFG;
          else if (kind_q == NAL_TYPE) phase_q = lp2sc_pkg::PH_NAL_LEN;
          else phase_q = lp2sc_pkg::PH_EOS;
        end
      end
      lp2sc_pkg::PH_CFG: begin
        if (pos_q == LenSizePos)
          len_size_q = 3'((b & lp2sc_pkg::LEN_SIZE_MASK) + 8'd1);
        if (pos_q >= SpsCountPos) phase_q = lp2sc_pkg::PH_SPS_LEN;
      end
      lp2sc_pkg::PH_SPS_LEN: begin
        collect_length(b, 3'd2, done);
        if (done)
          phase_q = (remaining_q != 0) ? lp2sc_pkg::PH_SPS_DATA : lp2sc_pkg::PH_PPS_COUNT;
      end
      lp2sc_pkg::PH_SPS_DATA: begin
        emit(b, 1'b1);
        remaining_q--;
        if (remaining_q == 0) phase_q = lp2sc_pkg::PH_PPS_COUNT;
      end
      lp2sc_pkg::PH_PPS_COUNT: phase_q = lp2sc_pkg::PH_PPS_LEN;
      lp2sc_pkg::PH_PPS_LEN: begin
        collect_length(b, 3'd2, done);
        if (done)
          phase_q = (remaining_q != 0) ? lp2sc_pkg::PH_PPS_DATA : lp2sc_pkg::PH_TRAIL;
      end
      lp2sc_pkg::PH_PPS_DATA: begin
        emit(b, 1'b1);
        remaining_q--;
        if (remaining_q == 0) phase_q = lp2sc_pkg::PH_TRAIL;
      end
      lp2sc_pkg::PH_NAL_LEN: begin
        collect_length(b, len_size_q, done);
        if (done)
          phase_q = (remaining_q != 0) ? lp2sc_pkg::PH_NAL_DATA : lp2sc_pkg::PH_NAL_LEN;
      end
      lp2sc_pkg::PH_NAL_DATA: begin
        emit(b, 1'b1);
        remaining_q--;
        if (remaining_q == 0) phase_q = lp2sc_pkg::PH_NAL_LEN;
      end
      default: ;
    endcase

    if (pos_q != 24'hFF_FFFF) pos_q++;

    if (last) begin
      case (phase_q)
        lp2sc_pkg::PH_TRAIL:   ;
        lp2sc_pkg::PH_EOS:     seq = 1'b1;
        lp2sc_pkg::PH_NAL_LEN: trunc = (len_seen_q != 0);
        default:               trunc = 1'b1;
      endcase
      // a tag end with no byte to carry it gets a status-only result
      if (seq || byte_results.size() == 0) emit(8'h00, 1'b0);
    end

    pts = tag_dts_q + {8'h00, cts_q};
    foreach (byte_results[k]) byte_results[k].pts = pts;
    if (byte_results.size() > 0) begin
      byte_results[byte_results.size() - 1].run_last = 1'b1;
      if (last) begin
        byte_results[byte_results.size() - 1].tag_end = 1'b1;
        byte_results[byte_results.size() - 1].seq_end = seq;
        byte_results[byte_results.size() - 1].trunc = trunc;
      end
    end
    foreach (byte_results[k]) annexb_queue.insert(annexb_queue.size(), byte_results[k]);

    if (last) clear_tag();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    stream_result_t want;
    if (!rst_ni) begin
      clear_tag();
      len_size_q = 3'd4;
      kind_q = '0;
      cts_q = '0;
      tag_dts_q = '0;
      annexb_queue.delete();
      results_seen = 0;
      mismatches_o = 0;
      outstanding_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) parse_tag_byte(in_byte_i, in_last_i, dts_in_i);
      if (out_valid_i && out_ready_i) begin
        if (annexb_queue.size() == 0) begin
          report_mismatch("result arrived with nothing outstanding");
        end else begin
          want = annexb_queue.pop_front();
          check_field("out_byte", out_byte_i, want.data);
          check_field("byte_valid", byte_valid_i, want.byte_valid);
          check_field("run_last", run_last_i, want.run_last);
          check_field("tag_end", tag_end_i, want.tag_end);
          check_field("sequence_end", sequence_end_i, want.seq_end);
          check_field("truncated", truncated_i, want.trunc);
          check_field("pts", pts_i, want.pts);
        end
        results_seen++;
      end
      outstanding_o = annexb_queue.size();
    end
  end

endmodule

// ===== test/avc_length_prefix_to_start_code_top_tb.sv =====
module avc_length_prefix_to_start_code_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // FLV AVC packet types
  localparam logic [7:0] PktConfig    = 8'd0;
  localparam logic [7:0] PktNal       = 8'd1;
  localparam logic [7:0] PktEndOfSeq  = 8'd2;
  // keyframe + AVC codec id, the usual first byte of a video tag
  localparam logic [7:0] AvcCodecByte = 8'h17;
  // tag body offset of lengthSizeMinusOne in the config record
  localparam int unsigned LenSizeIdx  = 9;
  localparam int unsigned RandomItems = 350;
  localparam int unsigned DrainCycles = 16;
  // run limit, with margin for long gaps, four start code bytes per item and
  // long output stalls
  localparam int unsigned RunLimitNs  = 10_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic [31:0] dts_in = 32'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        run_last;
  logic        tag_end;
  logic        seq_end;
  logic        truncated;
  logic [31:0] pts;

  int          mismatches;
  int          outstanding;

  // body of the tag being built, one entry per item
  logic [7:0]  tag_bytes[$];
  // NAL length size the block should be using, tracked from config tags
  int unsigned nal_len_size = 4;
  int unsigned bytes_sent;
  // no idling on either side while set
  bit          calm_stretch = 1'b0;

  avc_length_prefix_to_start_code_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_byte_i      (in_byte),
    .in_last_i      (in_last),
    .dts_in_i       (dts_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte),
    .byte_valid_o   (byte_valid),
    .run_last_o     (run_last),
    .tag_end_o      (tag_end),
    .sequence_end_o (seq_end),
    .truncated_o    (truncated),
    .pts_o          (pts)
  );

  lp2sc_stream_checker #(
    .CONFIG_TYPE (PktConfig),
    .NAL_TYPE    (PktNal)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_byte_i      (in_byte),
    .in_last_i      (in_last),
    .dts_in_i       (dts_in),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_i     (out_byte),
    .byte_valid_i   (byte_valid),
    .run_last_i     (run_last),
    .tag_end_i      (tag_end),
    .sequence_end_i (seq_end),
    .truncated_i    (truncated),
    .pts_i          (pts),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a rising edge; returns at the edge where the item was taken.
  // in_ready is sampled at the falling edge, so the decision never races
  // with the block's own updates at the rising edge.
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic [31:0] dts);
    int unsigned gap;
    bit          taken;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    dts_in   <= dts;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // appends one byte to the tag being built
  task automatic add_byte(input logic [7:0] b);
    tag_bytes.insert(tag_bytes.size(), b);
  endtask

  // Sends the built tag. dts only matters on the first byte, so the rest
  // carry noise there.
  task automatic send_tag(input logic [31:0] dts);
    for (int i = 0; i < tag_bytes.size(); i++)
      send_byte(tag_bytes[i], i == tag_bytes.size() - 1, (i == 0) ? dts : $urandom());
    // any type 0 tag long enough to reach the size byte reprograms it
    if (tag_bytes.size() > LenSizeIdx && tag_bytes[1] == PktConfig)
      nal_len_size = (tag_bytes[LenSizeIdx] & lp2sc_pkg::LEN_SIZE_MASK) + 1;
    bytes_sent += tag_bytes.size();
    tag_bytes.delete();
  endtask

  // codec byte, packet type, 24-bit composition time
  task automatic push_header(input logic [7:0] kind, input logic [23:0] cts);
    add_byte(($urandom_range(0, 3) == 0) ? 8'($urandom()) : AvcCodecByte);
    add_byte(kind);
    add_byte(cts[23:16]);
    add_byte(cts[15:8]);
    add_byte(cts[7:0]);
  endtask

  task automatic push_length(input logic [31:0] len, input int unsigned width);
    for (int i = int'(width) - 1; i >= 0; i--)
      add_byte(len[8 * i +: 8]);
  endtask

  task automatic push_payload(input int unsigned n);
    repeat (n) add_byte(8'($urandom()));
  endtask

  // AVC decoder configuration record with one SPS and one PPS
  task automatic push_config_record(input logic [1:0] size_sel, input int unsigned sps_len,
                                    input int unsigned pps_len, input int unsigned tail);
    add_byte(8'h01);
    push_payload(3);                                  // profile, compat, level
    add_byte({6'($urandom()), size_sel});             // lengthSizeMinusOne
    push_payload(1);                                  // SPS count, ignored
    push_length(sps_len, 2);
    push_payload(sps_len);
    push_payload(1);                                  // PPS count, ignored
    push_length(pps_len, 2);
    push_payload(pps_len);
    push_payload(tail);
  endtask

  // Output side: ready in bursts with random stalls between them. Each
  // step sees at most one assignment, since a clock edge lies between any two.
  initial begin : receiver
    int unsigned stall;
    forever begin
      @(posedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned nals;
    int unsigned len;
    int unsigned cut;
    logic [31:0] dts;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed tags ---
    // codec byte alone: header cut short, pts falls back to dts
    add_byte(AvcCodecByte);
    send_tag(32'hFFFF_FFFF);

    // config record: max composition time wraps pts, 1-byte NAL lengths,
    // empty SPS (start code only), one-byte PPS closing the tag
    push_header(PktConfig, 24'hFF_FFFF);
    push_config_record(2'd0, 0, 1, 0);
    send_tag(32'hFFFF_FF00);

    // NAL tag: an empty NAL, then a two-byte one ending the tag cleanly
    push_header(PktNal, 24'h00_0000);
    push_length(0, nal_len_size);
    push_length(2, nal_len_size);
    push_payload(2);
    send_tag(32'h0000_0000);

    // end of sequence: one status result with sequence_end
    push_header(PktEndOfSeq, 24'h00_0102);
    send_tag($urandom());

    // --- random tags ---
    // Mostly well-formed NAL and config tags with random content; some cut
    // short at a random point, some pure noise.
    bytes_sent = 0;
    while (bytes_sent < RandomItems) begin
      calm_stretch = ($urandom_range(0, 4) == 0);
      dts = ($urandom_range(0, 9) == 0) ? ($urandom() | 32'hFF00_0000) : $urandom();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        push_header(PktNal, 24'($urandom()));
        nals = $urandom_range(1, 4);
        repeat (nals) begin
          r = $urandom_range(0, 99);
          if (r < 10) len = 0;
          else if (r < 85) len = $urandom_range(1, 12);
          else len = $urandom_range(13, 60);
          push_length(len, nal_len_size);
          push_payload(len);
        end
      end else if (r < 70) begin
        push_header(PktConfig, 24'($urandom()));
        push_config_record(2'($urandom()), $urandom_range(0, 8), $urandom_range(0, 8),
                           $urandom_range(0, 3));
      end else if (r < 80) begin
        push_header(8'($urandom_range(PktEndOfSeq, 255)), 24'($urandom()));
        push_payload($urandom_range(0, 3));
      end else begin
        push_payload($urandom_range(1, 16));
      end
      // broken tag: ends somewhere inside
      if (r < 80 && $urandom_range(0, 99) < 15) begin
        cut = $urandom_range(1, tag_bytes.size());
        while (tag_bytes.size() > cut) void'(tag_bytes.pop_back());
      end
      send_tag(dts);
    end
    calm_stretch = 1'b0;
    in_valid <= 1'b0;

    // wait for every predicted result, then watch for strays
    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(RunLimitNs);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lp2sc_pkg.sv
hdl/lp2sc_front.sv
hdl/lp2sc_fifo.sv
hdl/lp2sc_back.sv
hdl/avc_length_prefix_to_start_code_top.sv
test/lp2sc_stream_checker.sv
test/avc_length_prefix_to_start_code_top_tb.sv
